>>> sv/rtphc_pkg.sv
// ----------------------------------------------------------------------------
// rtphc_pkg
// shared constants and types for the rtp header checker
// ----------------------------------------------------------------------------
package rtphc_pkg;

    localparam int unsigned LENGTH_BITS = 16;
    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned FRAME_MAX = 64;
    localparam int unsigned FRAME_W = 7;
    localparam int unsigned OUT_W = 120;

    localparam logic [FRAME_W-1:0] FRAME_RESET = 7'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_VERSION   = 3'd2;
    localparam logic [2:0] ST_PADDING   = 3'd3;
    localparam logic [2:0] ST_EXTENSION = 3'd4;
    localparam logic [2:0] ST_CSRC      = 3'd5;
    localparam logic [2:0] ST_MISFIT    = 3'd6;

    localparam logic [1:0] RTP_VERSION = 2'd2;

    typedef struct packed {
        logic [31:0]            first_word;
        logic [31:0]            stamp;
        logic [31:0]            source;
        logic [LENGTH_BITS-1:0] size;
        logic [6:0]             offset;
        logic                   rem_zero;
    } t_dgram_info;

endpackage

>>> sv/rtphc_accum.sv
// ----------------------------------------------------------------------------
// rtphc_accum
// per-byte header capture, byte counter and payload frame remainder
// ----------------------------------------------------------------------------
module rtphc_accum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [7:0]                     i_byte,
    input  logic                           i_last,
    input  logic [rtphc_pkg::FRAME_W-1:0]  i_frame_bytes,
    output rtphc_pkg::t_dgram_info         o_info
);
    import rtphc_pkg::*;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [31:0]            r_first, n_first;
    logic [31:0]            r_stamp, n_stamp;
    logic [31:0]            r_source, n_source;
    logic [5:0]             r_rem, n_rem;

    logic [3:0]             cc;
    logic [6:0]             offset;
    logic [FRAME_W-1:0]     fsize;
    logic [6:0]             rem_inc;
    logic                   in_payload;

    always_comb begin
        n_first  = r_first;
        n_stamp  = r_stamp;
        n_source = r_source;
        if (r_count < LENGTH_BITS'(4)) begin
            n_first = {r_first[23:0], i_byte};
        end else if (r_count < LENGTH_BITS'(8)) begin
            n_stamp = {r_stamp[23:0], i_byte};
        end else if (r_count < LENGTH_BITS'(HEADER_BYTES)) begin
            n_source = {r_source[23:0], i_byte};
        end

        cc     = n_first[27:24];
        offset = 7'(HEADER_BYTES) + {1'b0, cc, 2'b00};

        if (i_frame_bytes == '0) begin
            fsize = FRAME_W'(1);
        end else if (i_frame_bytes > FRAME_W'(FRAME_MAX)) begin
            fsize = FRAME_W'(FRAME_MAX);
        end else begin
            fsize = i_frame_bytes;
        end

        in_payload = r_count >= LENGTH_BITS'(offset);
        rem_inc    = {1'b0, r_rem} + 7'd1;
        n_rem      = r_rem;
        if (in_payload) begin
            n_rem = (rem_inc >= fsize) ? 6'd0 : rem_inc[5:0];
        end

        n_count = (r_count != COUNT_MAX) ? r_count + LENGTH_BITS'(1) : r_count;

        o_info.first_word = n_first;
        o_info.stamp      = n_stamp;
        o_info.source     = n_source;
        o_info.size       = n_count;
        o_info.offset     = offset;
        o_info.rem_zero   = (n_rem == 6'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_first  <= '0;
            r_stamp  <= '0;
            r_source <= '0;
            r_rem    <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_count  <= '0;
                r_first  <= '0;
                r_stamp  <= '0;
                r_source <= '0;
                r_rem    <= '0;
            end else begin
                r_count  <= n_count;
                r_first  <= n_first;
                r_stamp  <= n_stamp;
                r_source <= n_source;
                r_rem    <= n_rem;
            end
        end
    end

endmodule

>>> sv/rtphc_verdict.sv
// ----------------------------------------------------------------------------
// rtphc_verdict
// status priority, payload length and the result register
// ----------------------------------------------------------------------------
module rtphc_verdict (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  rtphc_pkg::t_dgram_info         i_info,
    input  logic                           i_take,
    output logic                           o_valid,
    output logic [rtphc_pkg::OUT_W-1:0]    o_data
);
    import rtphc_pkg::*;

    logic                   r_valid;
    logic [OUT_W-1:0]       r_data, n_data;
    logic [2:0]             status;
    logic [LENGTH_BITS-1:0] offset_ext;
    logic [LENGTH_BITS-1:0] plen;

    always_comb begin
        offset_ext = LENGTH_BITS'(i_info.offset);
        if (i_info.size < LENGTH_BITS'(HEADER_BYTES)) begin
            status = ST_SHORT;
        end else if (i_info.first_word[31:30] != RTP_VERSION) begin
            status = ST_VERSION;
        end else if (i_info.first_word[29]) begin
            status = ST_PADDING;
        end else if (i_info.first_word[28]) begin
            status = ST_EXTENSION;
        end else if (offset_ext > i_info.size) begin
            status = ST_CSRC;
        end else if (!i_info.rem_zero) begin
            status = ST_MISFIT;
        end else begin
            status = ST_OK;
        end

        plen = (i_info.size >= offset_ext) ? i_info.size - offset_ext : '0;

        n_data = {3'b000,
                  16'(plen),
                  i_info.offset,
                  i_info.first_word[27:24],
                  i_info.source,
                  i_info.stamp,
                  i_info.first_word[15:0],
                  i_info.first_word[22:16],
                  status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> sv/rtp_header_checker.sv
// ----------------------------------------------------------------------------
// rtp_header_checker
// checks the fixed rtp header of a datagram streamed one byte per beat
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s         in         one datagram byte, tlast on the final byte
//  m         out        one verdict per datagram (status and header fields)
//  cfg       in         frame_bytes, 7 bits
//
//  one byte per cycle, save for the final-byte hold below; a byte is registered in
//  the input register and its verdict is then registered in the result register
//  a final byte waits in the input register while a previous verdict is
//  still held by the downstream; other bytes are never held up
//  synchronous active-low reset clears all datagram state, frame_bytes to 4
// ----------------------------------------------------------------------------
module rtp_header_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,  // data_byte
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // status[2:0] payload_type[9:3] sequence_number[25:10] time_stamp[57:26]
    // source_id[89:58] csrc_count[93:90] payload_offset[100:94]
    // payload_length[116:101], zero pad above
    output logic [rtphc_pkg::OUT_W-1:0]       o_m_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rtphc_pkg::FRAME_W-1:0]     i_cfg_data
);
    import rtphc_pkg::*;

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic [FRAME_W-1:0] r_frame_bytes;
    logic               out_free;
    logic               step;
    t_dgram_info        info;

    assign out_free   = !o_m_tvalid || i_m_tready;
    assign step       = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= FRAME_RESET;
        end else if (i_cfg_valid) begin
            r_frame_bytes <= i_cfg_data;
        end
    end

    rtphc_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_frame_bytes (r_frame_bytes),
        .o_info        (info)
    );

    rtphc_verdict u_verdict (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && r_in_last),
        .i_info  (info),
        .i_take  (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata)
    );

endmodule

>>> dv/rtp_header_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_header_checker_tb
// streams rtp datagrams into the checker with random gaps on both sides and
// compares every verdict beat against a cycle-free model of the header checks
// ----------------------------------------------------------------------------
module rtp_header_checker_tb;
    import rtphc_pkg::*;

    typedef struct packed {
        logic [15:0] plen;
        logic [6:0]  offset;
        logic [3:0]  cc;
        logic [31:0] source;
        logic [31:0] stamp;
        logic [15:0] seq;
        logic [6:0]  pt;
        logic [2:0]  status;
    } t_verdict;

    class t_verdict_board;
        logic [FRAME_W-1:0]     frame_bytes;
        logic [LENGTH_BITS-1:0] byte_count;
        logic [31:0]            first_word;
        logic [31:0]            stamp;
        logic [31:0]            source;
        logic [5:0]             remainder;
        t_verdict               pending[$];
        int                     errors;

        function void clear_dgram();
            byte_count = '0;
            first_word = '0;
            stamp = '0;
            source = '0;
            remainder = '0;
        endfunction

        function void reset_all();
            frame_bytes = FRAME_RESET;
            clear_dgram();
            pending.delete();
            errors = 0;
        endfunction

        function int frame_in_force();
            if (frame_bytes == 0)
                return 1;
            if (frame_bytes > FRAME_MAX)
                return int'(FRAME_MAX);
            return int'(frame_bytes);
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int idx, offset, nxt, size;
            t_verdict v;
            idx = int'(byte_count);
            if (idx < 4)
                first_word = {first_word[23:0], b};
            else if (idx < 8)
                stamp = {stamp[23:0], b};
            else if (idx < HEADER_BYTES)
                source = {source[23:0], b};
            offset = HEADER_BYTES + 4 * first_word[27:24];
            if (idx >= offset) begin
                nxt = remainder + 1;
                remainder = (nxt >= frame_in_force()) ? 6'd0 : nxt[5:0];
            end
            if (byte_count != {LENGTH_BITS{1'b1}})
                byte_count++;
            if (!last)
                return;
            size = int'(byte_count);
            if (size < HEADER_BYTES)
                v.status = ST_SHORT;
            else if (first_word[31:30] != RTP_VERSION)
                v.status = ST_VERSION;
            else if (first_word[29])
                v.status = ST_PADDING;
            else if (first_word[28])
                v.status = ST_EXTENSION;
            else if (offset > size)
                v.status = ST_CSRC;
            else if (remainder != 0)
                v.status = ST_MISFIT;
            else
                v.status = ST_OK;
            v.pt = first_word[22:16];
            v.seq = first_word[15:0];
            v.stamp = stamp;
            v.source = source;
            v.cc = first_word[27:24];
            v.offset = offset[6:0];
            v.plen = (size >= offset) ? 16'(size - offset) : 16'd0;
            pending.push_back(v);
            clear_dgram();
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            t_verdict got, want;
            got = data[$bits(t_verdict)-1:0];
            if (pending.size() == 0) begin
                $error("verdict beat with nothing pending");
                errors++;
                return;
            end
            want = pending.pop_front();
            cmp("status", want.status, got.status);
            cmp("payload_type", want.pt, got.pt);
            cmp("sequence_number", want.seq, got.seq);
            cmp("time_stamp", want.stamp, got.stamp);
            cmp("source_id", want.source, got.source);
            cmp("csrc_count", want.cc, got.cc);
            cmp("payload_offset", want.offset, got.offset);
            cmp("payload_length", want.plen, got.plen);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [7:0]         i_s_tdata;
    logic               i_s_tlast;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [OUT_W-1:0]   o_m_tdata;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [FRAME_W-1:0] i_cfg_data;

    t_verdict_board   board;
    logic [7:0]       dgram[$];
    bit               calm_tx;
    bit               calm_rx;
    bit               steady_tx;
    bit               held_off;
    int               bytes_sent;
    int               dgrams_sent;
    int               verdicts_seen;
    int               rnd_start;

    rtp_header_checker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] hdr(logic [1:0] ver, logic p, logic x, logic [3:0] cc);
        logic [31:0] w;
        w = $urandom;
        w[31:24] = {ver, p, x, cc};
        return w;
    endfunction

    function automatic int pick_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic send_range(int from, int upto, bit with_last);
        int gap;
        for (int i = from; i < upto; i++) begin
            gap = steady_tx ? 0 : pick_gap(calm_tx);
            if (gap > 0) begin
                i_s_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_s_tvalid = 1'b1;
            i_s_tdata = dgram[i];
            i_s_tlast = with_last && (i == upto - 1);
            do @(posedge i_clk); while (!o_s_tready);
            board.note_byte(i_s_tdata, i_s_tlast);
            bytes_sent++;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b0;
        i_s_tlast = 1'b0;
    endtask

    task automatic make_dgram(logic [31:0] w0, int size);
        dgram.delete();
        for (int i = 0; i < size; i++)
            dgram.push_back(i < 4 ? w0[31 - 8 * i -: 8] : 8'($urandom));
    endtask

    task automatic run_dgram(logic [31:0] w0, int size);
        make_dgram(w0, size);
        send_range(0, size, 1'b1);
        dgrams_sent++;
        if ($urandom_range(0, 7) == 0)
            calm_tx = !calm_tx;
    endtask

    task automatic wait_idle();
        i_s_tvalid = 1'b0;
        while (board.pending.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_frame(logic [FRAME_W-1:0] value);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.frame_bytes = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_dgram();
        int fs, cc, off, nfr, plen, kind, size;
        logic [31:0] w0;
        fs = board.frame_in_force();
        kind = $urandom_range(0, 99);
        cc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
        off = HEADER_BYTES + 4 * cc;
        if (kind < 75) begin
            nfr = (fs > 16) ? $urandom_range(0, 1) : $urandom_range(0, 3);
            plen = nfr * fs;
            if ($urandom_range(0, 3) == 0 && fs > 1)
                plen += $urandom_range(1, fs - 1);
            w0 = hdr(RTP_VERSION, 1'b0, 1'b0, 4'(cc));
            size = off + plen;
        end else if (kind < 90) begin
            w0 = hdr(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 4'(cc));
            size = $urandom_range(1, off + 8);
        end else begin
            w0 = $urandom;
            size = $urandom_range(1, 20);
        end
        run_dgram(w0, size);
    endtask

    function automatic logic [FRAME_W-1:0] pick_frame();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd127;
            2: return 7'd64;
            3: return 7'd1;
            default: return 7'($urandom_range(1, 12));
        endcase
    endfunction

    // result side, with one long hold-off to back the block up
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (verdicts_seen == 30 && !held_off) begin
                held_off = 1'b1;
                i_m_tready = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            if ($urandom_range(0, 7) == 0)
                calm_rx = !calm_rx;
            repeat (pick_gap(calm_rx)) begin
                i_m_tready = 1'b0;
                @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            board.check_result(o_m_tdata);
            verdicts_seen++;
            @(negedge i_clk);
        end
    end

    initial begin
        board = new();
        board.reset_all();
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // header checks in priority order
        run_dgram(hdr(RTP_VERSION, 1'b0, 1'b0, 4'd0), 1);
        run_dgram(32'hFFFF_FFFF, 11);
        run_dgram(32'h8000_0000, 12);
        run_dgram(hdr(2'd0, 1'b0, 1'b0, 4'd0), 16);
        run_dgram(hdr(2'd1, 1'b0, 1'b0, 4'd1), 16);
        run_dgram(hdr(2'd3, 1'b1, 1'b1, 4'd0), 16);
        run_dgram(hdr(RTP_VERSION, 1'b1, 1'b1, 4'd0), 16);
        run_dgram(hdr(RTP_VERSION, 1'b0, 1'b1, 4'd0), 16);
        run_dgram(32'h8FFF_FFFF, 12);
        run_dgram(32'h8FFF_FFFF, 71);
        run_dgram(32'h8FFF_FFFF, 72);
        run_dgram(hdr(RTP_VERSION, 1'b0, 1'b0, 4'd0), 17);
        run_dgram(hdr(RTP_VERSION, 1'b0, 1'b0, 4'd1), 24);

        // frame size extremes, out-of-range values clamp
        write_frame(7'd0);
        run_dgram(hdr(RTP_VERSION, 1'b0, 1'b0, 4'd0), 19);
        write_frame(7'd127);
        run_dgram(hdr(RTP_VERSION, 1'b0, 1'b0, 4'd0), 76);
        run_dgram(hdr(RTP_VERSION, 1'b0, 1'b0, 4'd0), 75);
        write_frame(7'd65);
        run_dgram(hdr(RTP_VERSION, 1'b0, 1'b0, 4'd0), 140);
        write_frame(7'd1);
        run_dgram(hdr(RTP_VERSION, 1'b0, 1'b0, 4'd0), 13);

        // frame size changed partway through the payload
        write_frame(7'd64);
        make_dgram(hdr(RTP_VERSION, 1'b0, 1'b0, 4'd0), 42);
        send_range(0, 32, 1'b0);
        write_frame(7'd5);
        send_range(32, 42, 1'b1);
        dgrams_sent++;

        // datagram longer than the byte counter can hold
        write_frame(7'd3);
        steady_tx = 1'b1;
        run_dgram(hdr(RTP_VERSION, 1'b0, 1'b0, 4'd0), 65540);
        steady_tx = 1'b0;

        rnd_start = bytes_sent;
        dgrams_sent = 0;
        while (bytes_sent - rnd_start < 1700 || dgrams_sent < 40) begin
            if (dgrams_sent % 12 == 0)
                write_frame(pick_frame());
            random_dgram();
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
sv/rtphc_pkg.sv
sv/rtphc_accum.sv
sv/rtphc_verdict.sv
sv/rtp_header_checker.sv
dv/rtp_header_checker_tb.sv
